>>> src/abrc_pkg.sv
// Shared constants and types for the arithmetic baud register calculator.
`default_nettype none

package abrc_pkg;

    localparam int WORD_W    = 32;
    localparam int BAUD_W    = 16;
    localparam int CODE_W    = 3;
    localparam int DIV_STEPS = WORD_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CODE_X16 = 3'h0;
    localparam code_t CODE_X8  = 3'h2;
    localparam code_t CODE_X3  = 3'h4;

endpackage

`default_nettype wire

>>> src/async_baud_register_calc.sv
// Arithmetic baud register calculator: a fully pipelined restoring divider.
//
// A word enters when start is high and busy is low. busy is held low, so a
// new word may be presented on every clock cycle. Each word carries the
// wanted bit rate (baud_rate) and the reference clock (clock_hz). The
// block picks the largest oversampling factor of 16, 8 or 3 whose product
// with the rate fits under the clock, and returns the arithmetic baud value
// with its sampling-mode code, or error when nothing fits or the clock is 0.
// Each result is shown for one cycle, marked by done; one result per cycle
// at full throughput. The divider yields one quotient bit per stage over 32
// stages, behind an input stage, a factor selection stage and a remainder
// set-up stage, and ahead of an output stage. Results leave in the order
// the words came in. The receiver cannot hold results off, so nothing
// stalls inside. Reset clears every valid bit, so no result is strobed
// until fresh words arrive.
`default_nettype none

module async_baud_register_calc (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire abrc_pkg::word_t       baud_rate,
    input  wire abrc_pkg::word_t       clock_hz,
    output logic                       done,
    output logic                       error,
    output logic [abrc_pkg::BAUD_W-1:0] baud_value,
    output abrc_pkg::code_t            sample_code
);
    import abrc_pkg::*;

    // Input stage.
    logic  in_valid_reg;
    word_t in_rate_reg;
    word_t in_clk_reg;

    // Factor selection stage.
    logic  sel_valid_reg;
    logic  sel_err_reg;
    code_t sel_code_reg;
    word_t sel_num_reg;
    word_t sel_clk_reg;

    logic [WORD_W+3:0] rate_x16;
    logic [WORD_W+3:0] rate_x8;
    logic [WORD_W+3:0] rate_x3;
    logic [WORD_W+3:0] clk_ext;
    logic              fit16;
    logic              fit8;
    logic              fit3;
    logic              sel_err_next;
    code_t             sel_code_next;
    word_t             sel_num_next;

    // Divider stages: index 0 holds the starting remainder.
    logic  div_valid_reg [0:DIV_STEPS];
    logic  div_err_reg   [0:DIV_STEPS];
    code_t div_code_reg  [0:DIV_STEPS];
    word_t div_rem_reg   [0:DIV_STEPS];
    word_t div_quo_reg   [0:DIV_STEPS];
    word_t div_clk_reg   [0:DIV_STEPS];

    // Output stage.
    logic                done_reg;
    logic                error_reg;
    logic [BAUD_W-1:0]   baud_reg;
    code_t               code_reg;
    word_t               neg_quo;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_rate_reg <= baud_rate;
        in_clk_reg  <= clock_hz;
    end

    assign rate_x16 = {in_rate_reg, 4'b0000};
    assign rate_x8  = {1'b0, in_rate_reg, 3'b000};
    assign rate_x3  = {3'b000, in_rate_reg, 1'b0} + {4'b0000, in_rate_reg};
    assign clk_ext  = {4'b0000, in_clk_reg};
    assign fit16    = rate_x16 <= clk_ext;
    assign fit8     = rate_x8 <= clk_ext;
    assign fit3     = rate_x3 <= clk_ext;

    // When a factor fits, the chosen product never exceeds the clock, so it fits in one word.
    always_comb
    begin
        sel_err_next  = (in_clk_reg == '0) || !fit3;
        sel_code_next = CODE_X3;
        sel_num_next  = rate_x3[WORD_W-1:0];
        if (fit16)
        begin
            sel_code_next = CODE_X16;
            sel_num_next  = rate_x16[WORD_W-1:0];
        end
        else if (fit8)
        begin
            sel_code_next = CODE_X8;
            sel_num_next  = rate_x8[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            sel_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_err_reg  <= sel_err_next;
        sel_code_reg <= sel_code_next;
        sel_num_reg  <= sel_num_next;
        sel_clk_reg  <= in_clk_reg;
    end

    // When the product equals the clock the ratio is exactly one; a zero
    // remainder then gives a zero fraction, whose negation is also zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg[0] <= 1'b0;
        end
        else
        begin
            div_valid_reg[0] <= sel_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_err_reg[0]  <= sel_err_reg;
        div_code_reg[0] <= sel_code_reg;
        div_rem_reg[0]  <= (sel_num_reg == sel_clk_reg) ? '0 : sel_num_reg;
        div_quo_reg[0]  <= '0;
        div_clk_reg[0]  <= sel_clk_reg;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        logic [WORD_W:0] dbl;
        logic [WORD_W:0] diff;
        logic            ge;

        assign dbl  = {div_rem_reg[k-1], 1'b0};
        assign diff = dbl - {1'b0, div_clk_reg[k-1]};
        assign ge   = dbl >= {1'b0, div_clk_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k] <= 1'b0;
            end
            else
            begin
                div_valid_reg[k] <= div_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            div_err_reg[k]  <= div_err_reg[k-1];
            div_code_reg[k] <= div_code_reg[k-1];
            div_rem_reg[k]  <= ge ? diff[WORD_W-1:0] : dbl[WORD_W-1:0];
            div_quo_reg[k]  <= {div_quo_reg[k-1][WORD_W-2:0], ge};
            div_clk_reg[k]  <= div_clk_reg[k-1];
        end
    end

    // One minus the fraction, taken modulo one; the baud value is its top half.
    assign neg_quo = '0 - div_quo_reg[DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        error_reg <= div_err_reg[DIV_STEPS];
        baud_reg  <= div_err_reg[DIV_STEPS] ? '0 : neg_quo[WORD_W-1 -: BAUD_W];
        code_reg  <= div_err_reg[DIV_STEPS] ? CODE_X16 : div_code_reg[DIV_STEPS];
    end

    assign done        = done_reg;
    assign error       = error_reg;
    assign baud_value  = baud_reg;
    assign sample_code = code_reg;

    a_err_clears_fields : assert property (@(posedge clk) disable iff (!rst_n)
        done && error |-> baud_value == '0 && sample_code == CODE_X16)
        else $error("error result carries nonzero fields");

    a_code_legal : assert property (@(posedge clk) disable iff (!rst_n)
        done && !error |->
            sample_code == CODE_X16 || sample_code == CODE_X8 || sample_code == CODE_X3)
        else $error("illegal sampling code on a good result");

    a_rem_start_bound : assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[0] && !div_err_reg[0] |-> div_rem_reg[0] < div_clk_reg[0])
        else $error("starting remainder not below the clock");

    a_rem_end_bound : assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[DIV_STEPS] && !div_err_reg[DIV_STEPS] |->
            div_rem_reg[DIV_STEPS] < div_clk_reg[DIV_STEPS])
        else $error("final remainder not below the clock");

endmodule

`default_nettype wire

>>> tb/abrc_result_checker.sv
// Checker for the baud register calculator: predicts each result and compares it.
`timescale 1ns / 1ps

module abrc_result_checker
    import abrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire word_t                 baud_rate,
    input  wire word_t                 clock_hz,
    input  wire logic                  done,
    input  wire logic                  error,
    input  wire logic [BAUD_W-1:0]     baud_value,
    input  wire code_t                 sample_code,
    output int                         fail_count,
    output int                         in_flight
);

    localparam logic [63:0] OVS_X16 = 64'd16;
    localparam logic [63:0] OVS_X8  = 64'd8;
    localparam logic [63:0] OVS_X3  = 64'd3;

    typedef struct packed {
        logic              err;
        logic [BAUD_W-1:0] value;
        code_t             code;
    } baud_setting_t;

    baud_setting_t expected_settings[$];

    // Picks the largest oversampling factor that fits and forms the baud value
    // from a 32-bit fraction of the clock, all in 64-bit arithmetic.
    function automatic baud_setting_t calc_baud_setting(word_t rate, word_t ref_hz);
        baud_setting_t setting;
        logic [63:0]   wide_rate;
        logic [63:0]   wide_clk;
        logic [63:0]   factor;
        logic [63:0]   ratio;
        logic [63:0]   scale;
        logic [63:0]   scaled;
        setting.err   = 1'b1;
        setting.value = '0;
        setting.code  = '0;
        wide_rate     = 64'(rate);
        wide_clk      = 64'(ref_hz);
        factor        = '0;
        if (wide_clk != 0) begin
            if (wide_rate * OVS_X16 <= wide_clk) begin
                factor       = OVS_X16;
                setting.code = CODE_X16;
            end
            else if (wide_rate * OVS_X8 <= wide_clk) begin
                factor       = OVS_X8;
                setting.code = CODE_X8;
            end
            else if (wide_rate * OVS_X3 <= wide_clk) begin
                factor       = OVS_X3;
                setting.code = CODE_X3;
            end
        end
        if (factor != 0) begin
            ratio         = ((factor * wide_rate) << 32) / wide_clk;
            scale         = (64'd1 << 32) - ratio;
            scaled        = (scale << 16) >> 32;
            setting.err   = 1'b0;
            setting.value = scaled[BAUD_W-1:0];
        end
        return setting;
    endfunction

    initial begin
        fail_count = 0;
        in_flight  = 0;
    end

    always @(posedge clk) begin : track_words
        baud_setting_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_settings.size() == 0) begin
                    $error("result strobed with no word outstanding");
                    fail_count++;
                end
                else begin
                    want = expected_settings.pop_front();
                    if (error !== want.err) begin
                        $error("error: expected %0d, got %0d", want.err, error);
                        fail_count++;
                    end
                    if (baud_value !== want.value) begin
                        $error("baud_value: expected %0d, got %0d", want.value, baud_value);
                        fail_count++;
                    end
                    if (sample_code !== want.code) begin
                        $error("sample_code: expected %0d, got %0d", want.code, sample_code);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_settings.push_back(calc_baud_setting(baud_rate, clock_hz));
        end
        in_flight <= expected_settings.size();
    end

endmodule

>>> tb/async_baud_register_calc_test.sv
// Top of the baud register calculator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module async_baud_register_calc_test;
    import abrc_pkg::*;

    localparam int RANDOM_WORDS = 726;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam word_t WORD_MAX  = 32'hFFFF_FFFF;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    word_t             baud_rate;
    word_t             clock_hz;
    logic              done;
    logic              error;
    logic [BAUD_W-1:0] baud_value;
    code_t             sample_code;
    int                fail_count;
    int                in_flight;
    int                idle_pct;
    int                stalled_cycles;
    word_t             rand_rate;
    word_t             rand_clk;

    async_baud_register_calc dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .baud_rate   (baud_rate),
        .clock_hz    (clock_hz),
        .done        (done),
        .error       (error),
        .baud_value  (baud_value),
        .sample_code (sample_code)
    );

    abrc_result_checker result_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .baud_rate   (baud_rate),
        .clock_hz    (clock_hz),
        .done        (done),
        .error       (error),
        .baud_value  (baud_value),
        .sample_code (sample_code),
        .fail_count  (fail_count),
        .in_flight   (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the word is
    // taken, with start left high so that back-to-back words need no toggle.
    task automatic send_word(input word_t rate, input word_t ref_hz);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        baud_rate <= rate;
        clock_hz  <= ref_hz;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic make_random_word(output word_t rate, output word_t ref_hz);
        logic [63:0] product;
        int          kind;
        int          factor;
        kind = $urandom_range(9);
        if (kind <= 5)
        begin
            // Plausible pairs: the clock a small multiple of the rate, with jitter,
            // so every oversampling band and its edges are reached.
            ref_hz = $urandom_range(1) ? $urandom : $urandom_range(1, 200_000_000);
            rate   = ref_hz / word_t'($urandom_range(1, 40));
            rate   = rate + word_t'($urandom_range(2)) - 1;
        end
        else if (kind <= 7)
        begin
            rate   = $urandom;
            ref_hz = $urandom;
        end
        else if (kind == 8)
        begin
            case ($urandom_range(2))
                0:       factor = 3;
                1:       factor = 8;
                default: factor = 16;
            endcase
            rate    = $urandom_range(0, WORD_MAX / factor);
            product = 64'(rate) * 64'(factor) + 64'($urandom_range(2)) - 64'd1;
            ref_hz  = (product > 64'(WORD_MAX)) ? WORD_MAX : product[31:0];
        end
        else
        begin
            rate   = $urandom_range(1) ? word_t'($urandom_range(3)) : $urandom;
            ref_hz = $urandom_range(1) ? word_t'($urandom_range(3)) : $urandom;
        end
    endtask

    initial
    begin : watchdog
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        start     = 1'b0;
        baud_rate = '0;
        clock_hz  = '0;
        idle_pct  = 7;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Clock of zero, zero rate, extremes of both fields.
        send_word(32'd0, 32'd0);
        send_word(WORD_MAX, 32'd0);
        send_word(32'd0, 32'd1);
        send_word(32'd0, WORD_MAX);
        send_word(WORD_MAX, WORD_MAX);
        send_word(32'd1, 32'd1);
        send_word(32'd1, 32'd3);
        send_word(32'd1, WORD_MAX);
        // Each band at its exact edge and one hertz under it.
        send_word(32'd115200, 32'd1843200);
        send_word(32'd115200, 32'd1843199);
        send_word(32'd115200, 32'd921600);
        send_word(32'd115200, 32'd921599);
        send_word(32'd115200, 32'd345600);
        send_word(32'd115200, 32'd345599);
        send_word(32'h0FFF_FFFF, WORD_MAX);
        send_word(32'h1FFF_FFFF, WORD_MAX);
        send_word(32'h5555_5555, WORD_MAX);
        send_word(32'hAAAA_AAAA, WORD_MAX);
        send_word(32'd9600, 32'd48_000_000);
        send_word(32'd115200, 32'd8_000_000);
        send_word(32'd1_000_000, 32'd16_000_000);
        send_word(32'd3_000_000, 32'd16_000_000);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       idle_pct = 7;
                1:       idle_pct = 72;
                default: idle_pct = 0;
            endcase
            repeat (RANDOM_WORDS / 3)
            begin
                make_random_word(rand_rate, rand_clk);
                send_word(rand_rate, rand_clk);
            end
        end
        start <= 1'b0;

        while (in_flight != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
